/* rtl/core/thc_pkg.sv */
// Shared constants and fixed-point helpers for the temperature/humidity converter.
package thc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NUM_W     = 27;   // holds 1750 * 65535 plus rounding bias
  localparam int unsigned QUOT_W    = 11;   // quotient never exceeds 1750
  localparam int unsigned TEMP_W    = 11;
  localparam int unsigned HUM_W     = 10;

  localparam logic [BYTE_W-1:0] CRC_INIT     = 8'hFF;
  localparam logic [BYTE_W-1:0] CRC_POLY_RST = 8'h31;

  localparam logic [10:0]      TEMP_GAIN   = 11'd1750;       // tenths over full scale
  localparam logic [9:0]       HUM_GAIN    = 10'd1000;
  localparam logic [NUM_W-1:0] FULL_SCALE  = 27'd65535;
  localparam logic [NUM_W-1:0] CEIL_BIAS   = 27'd65534;
  localparam logic [NUM_W-1:0] OFFSET_NUM  = 27'd29490750;   // 450 tenths times full scale
  localparam logic [QUOT_W-1:0] OFFSET_T   = 11'd450;

  // floor(x / 65535) for x below 2^27: x = q0*65536 + lo, so the remainder
  // against 65535 is lo + q0, which stays below twice the divisor.
  function automatic logic [QUOT_W-1:0] div_full_scale(input logic [NUM_W-1:0] x);
    logic [QUOT_W-1:0] q0;
    logic [16:0]       rem;
    q0  = x[NUM_W-1:16];
    rem = {1'b0, x[15:0]} + {6'b0, q0};
    return (rem >= 17'd65535) ? (q0 + 11'd1) : q0;
  endfunction

endpackage

/* rtl/core/thc_crc_byte.sv */
// Eight MSB-first CRC-8 shift steps over one data byte.
module thc_crc_byte (
  input  logic [thc_pkg::BYTE_W-1:0] crc_i,
  input  logic [thc_pkg::BYTE_W-1:0] data_i,
  input  logic [thc_pkg::BYTE_W-1:0] poly_i,
  output logic [thc_pkg::BYTE_W-1:0] crc_o
);
  import thc_pkg::*;

  always_comb begin
    logic [BYTE_W-1:0] c;
    c = crc_i ^ data_i;
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ poly_i;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

/* rtl/core/temp_humidity_crc_convert.sv */
// Top level of the temperature/humidity frame checker and converter.
//
// Pulse start for one cycle with a six-byte sensor frame on the inputs;
// busy is never raised, so a frame may be issued on every clock cycle.
// Each frame yields exactly one result, shown for a single cycle with
// done_o high, after input, middle and result registers. The receiver
// cannot stall: capture the result in the cycle done_o is high or lose it.
// The rate is one frame per cycle, set by the three-stage register chain
// (input register, middle register, result register); the CRC walk is
// split one byte per stage. Each word is checked with CRC-8, MSB first,
// initial value 0xFF, polynomial from the configuration register (reset
// 0x31). A word whose CRC does not match reports valid low and zero for
// every field of that quantity. Temperature is reported as a distance from
// 45 degrees in tenths with a side flag; humidity in tenths of a percent.
// Write the polynomial only while no frame is in flight; the configuration
// channel is always ready.
module temp_humidity_crc_convert (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command side
  input  logic                        start,
  output logic                        busy,
  input  logic [thc_pkg::BYTE_W-1:0]  temp_msb_i,
  input  logic [thc_pkg::BYTE_W-1:0]  temp_lsb_i,
  input  logic [thc_pkg::BYTE_W-1:0]  temp_crc_i,
  input  logic [thc_pkg::BYTE_W-1:0]  hum_msb_i,
  input  logic [thc_pkg::BYTE_W-1:0]  hum_lsb_i,
  input  logic [thc_pkg::BYTE_W-1:0]  hum_crc_i,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [thc_pkg::BYTE_W-1:0]  cfg_data_i,
  // result side
  output logic                        done_o,
  output logic                        temp_valid_o,
  output logic                        temp_above_o,
  output logic [thc_pkg::TEMP_W-1:0]  temp_tenths_o,
  output logic                        hum_valid_o,
  output logic [thc_pkg::HUM_W-1:0]   hum_tenths_o
);
  import thc_pkg::*;

  // ---------------------------------------------------------------- config
  logic [BYTE_W-1:0] poly_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= CRC_POLY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      poly_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------- input stage
  logic              in_vld_q;
  logic [BYTE_W-1:0] t_hi_q, t_lo_q, t_rx_q, h_hi_q, h_lo_q, h_rx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  // Payload needs no reset; capture each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      t_hi_q <= temp_msb_i;
      t_lo_q <= temp_lsb_i;
      t_rx_q <= temp_crc_i;
      h_hi_q <= hum_msb_i;
      h_lo_q <= hum_lsb_i;
      h_rx_q <= hum_crc_i;
    end
  end

  // First CRC byte and the constant scalings of the raw words.
  logic [BYTE_W-1:0] t_crc1_d, h_crc1_d;
  logic [NUM_W-1:0]  t_num_d, h_num_d;

  thc_crc_byte u_t_crc_hi (
    .crc_i  (CRC_INIT),
    .data_i (t_hi_q),
    .poly_i (poly_q),
    .crc_o  (t_crc1_d)
  );

  thc_crc_byte u_h_crc_hi (
    .crc_i  (CRC_INIT),
    .data_i (h_hi_q),
    .poly_i (poly_q),
    .crc_o  (h_crc1_d)
  );

  // Widen both operands first so the product keeps every bit.
  assign t_num_d = NUM_W'({t_hi_q, t_lo_q}) * NUM_W'(TEMP_GAIN);
  assign h_num_d = NUM_W'({h_hi_q, h_lo_q}) * NUM_W'(HUM_GAIN);

  // --------------------------------------------------------- middle stage
  logic              mid_vld_q;
  logic [BYTE_W-1:0] t_crc1_q, h_crc1_q, t_lo2_q, h_lo2_q, t_rx2_q, h_rx2_q;
  logic [NUM_W-1:0]  t_num_q, h_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= 1'b0;
    end else begin
      mid_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      t_crc1_q <= t_crc1_d;
      h_crc1_q <= h_crc1_d;
      t_lo2_q  <= t_lo_q;
      h_lo2_q  <= h_lo_q;
      t_rx2_q  <= t_rx_q;
      h_rx2_q  <= h_rx_q;
      t_num_q  <= t_num_d;
      h_num_q  <= h_num_d;
    end
  end

  // Finish the CRC with the low byte, then divide by full scale.
  logic [BYTE_W-1:0] t_crc2, h_crc2;

  thc_crc_byte u_t_crc_lo (
    .crc_i  (t_crc1_q),
    .data_i (t_lo2_q),
    .poly_i (poly_q),
    .crc_o  (t_crc2)
  );

  thc_crc_byte u_h_crc_lo (
    .crc_i  (h_crc1_q),
    .data_i (h_lo2_q),
    .poly_i (poly_q),
    .crc_o  (h_crc2)
  );

  logic              t_ok, h_ok, t_above;
  logic [QUOT_W-1:0] t_floor, t_ceil, h_floor;
  logic              temp_valid_d, temp_above_d, hum_valid_d;
  logic [TEMP_W-1:0] temp_tenths_d;
  logic [HUM_W-1:0]  hum_tenths_d;

  always_comb begin
    t_ok    = (t_crc2 == t_rx2_q);
    h_ok    = (h_crc2 == h_rx2_q);
    // Comparing 1750*raw against 450*65535 equals comparing 175*raw to 45*65535.
    t_above = (t_num_q >= OFFSET_NUM);
    t_floor = div_full_scale(t_num_q);
    t_ceil  = div_full_scale(t_num_q + CEIL_BIAS);
    h_floor = div_full_scale(h_num_q);

    temp_valid_d  = t_ok;
    temp_above_d  = t_ok && t_above;
    temp_tenths_d = '0;
    if (t_ok) begin
      temp_tenths_d = t_above ? TEMP_W'(t_floor - OFFSET_T) : TEMP_W'(OFFSET_T - t_ceil);
    end

    // Drop the quantity to zero on a CRC mismatch.
    hum_valid_d  = h_ok;
    hum_tenths_d = h_ok ? h_floor[HUM_W-1:0] : '0;
  end

  // --------------------------------------------------------- result stage
  logic              done_q;
  logic              temp_valid_q, temp_above_q, hum_valid_q;
  logic [TEMP_W-1:0] temp_tenths_q;
  logic [HUM_W-1:0]  hum_tenths_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mid_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_vld_q) begin
      temp_valid_q  <= temp_valid_d;
      temp_above_q  <= temp_above_d;
      temp_tenths_q <= temp_tenths_d;
      hum_valid_q   <= hum_valid_d;
      hum_tenths_q  <= hum_tenths_d;
    end
  end

  assign done_o        = done_q;
  assign temp_valid_o  = temp_valid_q;
  assign temp_above_o  = temp_above_q;
  assign temp_tenths_o = temp_tenths_q;
  assign hum_valid_o   = hum_valid_q;
  assign hum_tenths_o  = hum_tenths_q;

endmodule

/* tb/sv/temp_humidity_crc_convert_test.sv */
// Self-checking testbench for the temperature/humidity frame checker and converter.
`timescale 1ns / 1ps

// One six-byte sensor frame as driven on the command side.
typedef struct {
  logic [thc_pkg::BYTE_W-1:0] temp_msb;
  logic [thc_pkg::BYTE_W-1:0] temp_lsb;
  logic [thc_pkg::BYTE_W-1:0] temp_crc;
  logic [thc_pkg::BYTE_W-1:0] hum_msb;
  logic [thc_pkg::BYTE_W-1:0] hum_lsb;
  logic [thc_pkg::BYTE_W-1:0] hum_crc;
} sensor_frame_t;

// One converted reading as shown on the result side.
typedef struct {
  logic                      temp_valid;
  logic                      temp_above;
  logic [thc_pkg::TEMP_W-1:0] temp_tenths;
  logic                      hum_valid;
  logic [thc_pkg::HUM_W-1:0]  hum_tenths;
} reading_t;

class frame_scoreboard;
  localparam int unsigned SCALE      = 65535;
  localparam int unsigned TEMP_SPAN  = 1750;
  localparam int unsigned HUM_SPAN   = 1000;
  localparam int unsigned OFFSET     = 450;
  localparam int unsigned ABOVE_EDGE = 45 * SCALE;

  logic [thc_pkg::BYTE_W-1:0] poly;
  reading_t    pending[$];
  int unsigned mismatches;
  int unsigned frames_in;
  int unsigned readings_out;
  int unsigned bad_words;
  int unsigned above_seen;

  function new();
    poly         = thc_pkg::CRC_POLY_RST;
    mismatches   = 0;
    frames_in    = 0;
    readings_out = 0;
    bad_words    = 0;
    above_seen   = 0;
  endfunction

  // CRC-8 over a 16-bit word, MSB first, seeded with all ones.
  function logic [7:0] word_crc(logic [7:0] hi, logic [7:0] lo);
    logic [15:0] word;
    logic [7:0]  c;
    logic        fb;
    word = {hi, lo};
    c    = thc_pkg::CRC_INIT;
    for (int i = 15; i >= 0; i--) begin
      fb = c[7] ^ word[i];
      c  = {c[6:0], 1'b0} ^ (fb ? poly : 8'h00);
    end
    return c;
  endfunction

  function reading_t convert(sensor_frame_t f);
    reading_t    r;
    int unsigned raw;
    int unsigned num;
    r = '{default: '0};
    if (word_crc(f.temp_msb, f.temp_lsb) == f.temp_crc) begin
      raw          = 32'({f.temp_msb, f.temp_lsb});
      num          = TEMP_SPAN * raw;
      r.temp_valid = 1'b1;
      if (175 * raw >= ABOVE_EDGE) begin
        r.temp_above  = 1'b1;
        r.temp_tenths = thc_pkg::TEMP_W'(num / SCALE - OFFSET);
      end else begin
        // round the quotient up on this side so the distance truncates
        r.temp_tenths = thc_pkg::TEMP_W'(OFFSET - (num + SCALE - 1) / SCALE);
      end
    end
    if (word_crc(f.hum_msb, f.hum_lsb) == f.hum_crc) begin
      raw          = 32'({f.hum_msb, f.hum_lsb});
      r.hum_valid  = 1'b1;
      r.hum_tenths = thc_pkg::HUM_W'((HUM_SPAN * raw) / SCALE);
    end
    return r;
  endfunction

  function void note_frame(sensor_frame_t f);
    reading_t r;
    r = convert(f);
    frames_in++;
    bad_words  += 32'(!r.temp_valid) + 32'(!r.hum_valid);
    above_seen += 32'(r.temp_above);
    pending.push_back(r);
  endfunction

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
    end
  endfunction

  function void check_reading(reading_t got);
    reading_t want;
    readings_out++;
    if (pending.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected reading: expected none, got tv=%0d ta=%0d tt=%0d hv=%0d ht=%0d",
               $realtime, got.temp_valid, got.temp_above, got.temp_tenths,
               got.hum_valid, got.hum_tenths);
      return;
    end
    want = pending.pop_front();
    check_field("temp_valid",  32'(want.temp_valid),  32'(got.temp_valid));
    check_field("temp_above",  32'(want.temp_above),  32'(got.temp_above));
    check_field("temp_tenths", 32'(want.temp_tenths), 32'(got.temp_tenths));
    check_field("hum_valid",   32'(want.hum_valid),   32'(got.hum_valid));
    check_field("hum_tenths",  32'(want.hum_tenths),  32'(got.hum_tenths));
  endfunction
endclass

module temp_humidity_crc_convert_test;

  localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no transaction at all
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_FRAMES  = 200;
  localparam int unsigned GOOD_CRC_PCT  = 85;
  localparam int unsigned SETTLE_CYCLES = 10;    // pipeline is three deep

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [thc_pkg::BYTE_W-1:0] temp_msb_i;
  logic [thc_pkg::BYTE_W-1:0] temp_lsb_i;
  logic [thc_pkg::BYTE_W-1:0] temp_crc_i;
  logic [thc_pkg::BYTE_W-1:0] hum_msb_i;
  logic [thc_pkg::BYTE_W-1:0] hum_lsb_i;
  logic [thc_pkg::BYTE_W-1:0] hum_crc_i;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [thc_pkg::BYTE_W-1:0] cfg_data_i;
  logic                       done_o;
  logic                       temp_valid_o;
  logic                       temp_above_o;
  logic [thc_pkg::TEMP_W-1:0] temp_tenths_o;
  logic                       hum_valid_o;
  logic [thc_pkg::HUM_W-1:0]  hum_tenths_o;

  frame_scoreboard sb = new();
  int unsigned     quiet_cycles;
  int unsigned     poly_writes;

  temp_humidity_crc_convert dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .temp_msb_i   (temp_msb_i),
    .temp_lsb_i   (temp_lsb_i),
    .temp_crc_i   (temp_crc_i),
    .hum_msb_i    (hum_msb_i),
    .hum_lsb_i    (hum_lsb_i),
    .hum_crc_i    (hum_crc_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .temp_valid_o (temp_valid_o),
    .temp_above_o (temp_above_o),
    .temp_tenths_o(temp_tenths_o),
    .hum_valid_o  (hum_valid_o),
    .hum_tenths_o (hum_tenths_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Capture every result in its single strobe cycle; the block cannot be stalled.
  always @(posedge clk_i) begin : result_monitor
    reading_t got;
    if (done_o === 1'b1) begin
      got.temp_valid  = temp_valid_o;
      got.temp_above  = temp_above_o;
      got.temp_tenths = temp_tenths_o;
      got.hum_valid   = hum_valid_o;
      got.hum_tenths  = hum_tenths_o;
      sb.check_reading(got);
    end
  end

  // Watchdog: any command, result or config transaction counts as progress.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Pick a raw word, leaning on the extremes and on the 45 degree boundary.
  function automatic logic [15:0] pick_raw();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      1:       return 16'($urandom_range(16865, 16840));
      default: return 16'($urandom);
    endcase
  endfunction

  // Build a frame; a word marked bad gets a CRC byte that cannot match.
  function automatic sensor_frame_t build_frame(logic [15:0] t_raw, logic [15:0] h_raw,
                                                bit t_good, bit h_good);
    sensor_frame_t f;
    f.temp_msb = t_raw[15:8];
    f.temp_lsb = t_raw[7:0];
    f.hum_msb  = h_raw[15:8];
    f.hum_lsb  = h_raw[7:0];
    f.temp_crc = sb.word_crc(f.temp_msb, f.temp_lsb);
    f.hum_crc  = sb.word_crc(f.hum_msb, f.hum_lsb);
    if (!t_good) f.temp_crc ^= 8'($urandom_range(255, 1));
    if (!h_good) f.hum_crc  ^= 8'($urandom_range(255, 1));
    return f;
  endfunction

  // Present a frame and hold start until the block takes it.
  task automatic send_frame(input sensor_frame_t f);
    start      <= 1'b1;
    temp_msb_i <= f.temp_msb;
    temp_lsb_i <= f.temp_lsb;
    temp_crc_i <= f.temp_crc;
    hum_msb_i  <= f.hum_msb;
    hum_lsb_i  <= f.hum_lsb;
    hum_crc_i  <= f.hum_crc;
    do @(posedge clk_i); while (busy);
    sb.note_frame(f);
  endtask

  // Drop start for a random number of cycles.
  task automatic sender_idle(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Stop issuing and wait for every outstanding reading.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_poly(input logic [thc_pkg::BYTE_W-1:0] p);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= p;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.poly = p;
    poly_writes++;
  endtask

  initial begin : stimulus
    int unsigned idle_pct;
    logic [7:0]  poly_plan [PHASES];

    rst_ni      <= 1'b0;
    start       <= 1'b0;
    temp_msb_i  <= '0;
    temp_lsb_i  <= '0;
    temp_crc_i  <= '0;
    hum_msb_i   <= '0;
    hum_lsb_i   <= '0;
    hum_crc_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    poly_writes  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames with the reset polynomial, back to back.
    send_frame(build_frame(16'h0000, 16'h0000, 1, 1));
    send_frame(build_frame(16'hFFFF, 16'hFFFF, 1, 1));
    send_frame(build_frame(16'd16851, 16'd16851, 1, 1));  // just below 45 degrees
    send_frame(build_frame(16'd16852, 16'd16852, 1, 1));  // first word above it
    send_frame(build_frame(16'd13107, 16'd13107, 1, 1));  // exact tenths, below
    send_frame(build_frame(16'd39321, 16'd39321, 1, 1));  // exact tenths, above
    send_frame(build_frame(16'h8000, 16'h7FFF, 1, 1));
    send_frame(build_frame(16'h00FF, 16'hFF00, 1, 1));
    send_frame(build_frame(16'hFFFF, 16'h0000, 0, 1));    // temperature CRC bad
    send_frame(build_frame(16'h0000, 16'hFFFF, 1, 0));    // humidity CRC bad
    send_frame(build_frame(16'd30000, 16'd30000, 0, 0));  // both bad
    send_frame(build_frame(16'hA5A5, 16'h5A5A, 0, 1));
    send_frame(build_frame(16'h5A5A, 16'hA5A5, 1, 0));
    drain();

    // Polynomial per phase: reset value, both extremes, a common one, two random.
    poly_plan[0] = thc_pkg::CRC_POLY_RST;
    poly_plan[1] = 8'h00;
    poly_plan[2] = 8'hFF;
    poly_plan[3] = 8'h07;
    poly_plan[4] = 8'($urandom);
    poly_plan[5] = 8'($urandom);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) write_poly(poly_plan[phase]);
      case (phase / 2)
        0:       idle_pct = 28;
        1:       idle_pct = 54;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        send_frame(build_frame(pick_raw(), pick_raw(),
                               $urandom_range(99) < GOOD_CRC_PCT,
                               $urandom_range(99) < GOOD_CRC_PCT));
        sender_idle(idle_pct);
      end
      // hold off until the pipeline is empty before the next register write
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d frames and %0d readings over %0d polynomial writes;",
             sb.frames_in, sb.readings_out, poly_writes);
    $display("%0d words failed their CRC, %0d temperatures at or above 45 degrees.",
             sb.bad_words, sb.above_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d readings never arrived", sb.mismatches,
               sb.pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
